@@ rtl/core/sdat_pkg.sv @@
// Shared types, constants and helpers of the adaptive-threshold step detector.
`default_nettype none

package sdat_pkg;

  localparam int unsigned LevelW = 24;
  localparam logic [LevelW-1:0] LevelMax = {LevelW{1'b1}};

  // Register reset values
  localparam logic [15:0] HystReset    = 16'd300;
  localparam logic [5:0]  WindowReset  = 6'd50;
  localparam logic [15:0] RefrReset    = 16'd200;
  localparam logic [15:0] InitThrReset = 16'd9800;

  // Last good sample after reset: resting on the z axis at 1 g
  localparam logic signed [15:0] GoodZReset = 16'sd9810;

  // Divide by ten: floor(2^35 / 10), result taken from bit 35 up
  localparam logic [31:0] DivRecip = 32'd3435973836;
  localparam int unsigned DivShift = 35;
  localparam int unsigned DivConst = 10;

  // Sequencer step counts
  localparam int unsigned CntW      = 4;
  localparam int unsigned SqSteps   = 3;
  localparam int unsigned RootSteps = 16;
  localparam logic [31:0] RootBitInit = 32'h4000_0000;

  typedef enum logic [1:0] {
    RegHyst    = 2'd0,
    RegWindow  = 2'd1,
    RegRefr    = 2'd2,
    RegInitThr = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    AxisX = 2'd0,
    AxisY = 2'd1,
    AxisZ = 2'd2
  } axis_e;

  typedef enum logic [3:0] {
    StIdle    = 4'd0,
    StSquare  = 4'd1,
    StRoot    = 4'd2,
    StDivMul  = 4'd3,
    StDivProd = 4'd4,
    StDivFix  = 4'd5,
    StWindow  = 4'd6,
    StDetect  = 4'd7,
    StEmit    = 4'd8
  } state_e;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               read_ok;
    logic               imu_ready;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic [31:0]       step_total;
    logic              step_taken;
    logic [LevelW-1:0] filtered_level;
    logic [LevelW-1:0] threshold_level;
    logic              armed_high;
  } out_item_t;

  typedef struct packed {
    logic [15:0] hysteresis_mm;
    logic [5:0]  window_samples;
    logic [15:0] refractory_ms;
    logic [15:0] initial_threshold_mm;
    logic        thr_load;
  } cfg_t;

  typedef struct packed {
    logic  accept;
    logic  sq_step;
    axis_e sq_sel;
    logic  root_step;
    logic  div_mul;
    logic  div_prod;
    logic  div_fix;
    logic  win_upd;
    logic  detect;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic item_skip;
  } sts_t;

  function automatic logic [LevelW-1:0] sat_level(input logic [31:0] v);
    logic [LevelW-1:0] r;
    r = (v > 32'(LevelMax)) ? LevelMax : v[LevelW-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/step_detector_adaptive_threshold_top.sv @@
// Top level of the adaptive-threshold step detector.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   input    | in_valid_i, in_ready_o, in_data_i         | in
//   result   | out_valid_o, out_ready_i, out_data_o      | out
//   config   | psel, penable, pwrite, paddr, pwdata,     | in/out
//            | prdata, pready                            |
//
// Each sample runs from acceptance to the result register through the sequencer
// steps in order: squaring of the three axes on a shared 16x16 multiplier,
// sixteen root digits, then the low-pass numerator, the reciprocal multiply,
// the divide-by-ten correction, the window update, the step decision and the
// result load; a new sample is not accepted until that result load is done.
// A sample with imu_ready low goes from acceptance straight to the result load.
// Reset is asynchronous and active low; control, config and detector state reset, working and result registers do not.
// A stalled result register holds the sequencer in its final step; the next
// transaction is taken once that result has been loaded.
`default_nettype none

module step_detector_adaptive_threshold_top #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  sdat_pkg::in_item_t        in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output sdat_pkg::out_item_t       out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  sdat_pkg::cfg_t cfg;
  sdat_pkg::cmd_t cmd;
  sdat_pkg::sts_t sts;

  // zero-wait-state register port
  assign pready = 1'b1;

  // configuration registers; a threshold write also reloads the live threshold
  sdat_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // sequencer: owns both handshakes and steps the datapath
  sdat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic, detector state and the result register
  sdat_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/sdat_regs.sv @@
// Configuration register file behind the APB-style port.
`default_nettype none

module sdat_regs (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output sdat_pkg::cfg_t   cfg_o
);

  logic [15:0] hyst_q, hyst_d;
  logic [5:0]  window_q, window_d;
  logic [15:0] refr_q, refr_d;
  logic [15:0] init_thr_q, init_thr_d;
  logic        wr_en;
  sdat_pkg::reg_idx_e idx;

  assign idx   = sdat_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    hyst_d     = hyst_q;
    window_d   = window_q;
    refr_d     = refr_q;
    init_thr_d = init_thr_q;
    if (wr_en) begin
      case (idx)
        sdat_pkg::RegHyst:    hyst_d     = pwdata[15:0];
        sdat_pkg::RegWindow:  window_d   = pwdata[5:0];
        sdat_pkg::RegRefr:    refr_d     = pwdata[15:0];
        sdat_pkg::RegInitThr: init_thr_d = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q     <= sdat_pkg::HystReset;
      window_q   <= sdat_pkg::WindowReset;
      refr_q     <= sdat_pkg::RefrReset;
      init_thr_q <= sdat_pkg::InitThrReset;
    end else begin
      hyst_q     <= hyst_d;
      window_q   <= window_d;
      refr_q     <= refr_d;
      init_thr_q <= init_thr_d;
    end
  end

  always_comb begin
    case (idx)
      sdat_pkg::RegHyst:    prdata = {16'd0, hyst_q};
      sdat_pkg::RegWindow:  prdata = {26'd0, window_q};
      sdat_pkg::RegRefr:    prdata = {16'd0, refr_q};
      sdat_pkg::RegInitThr: prdata = {16'd0, init_thr_q};
      default:              prdata = '0;
    endcase
  end

  // Threshold load is applied by the datapath in the same edge as the write
  always_comb begin
    cfg_o.hysteresis_mm        = hyst_q;
    cfg_o.window_samples       = window_q;
    cfg_o.refractory_ms        = refr_q;
    cfg_o.initial_threshold_mm = init_thr_d;
    cfg_o.thr_load             = wr_en && (idx == sdat_pkg::RegInitThr);
  end

endmodule

`default_nettype wire

@@ rtl/core/sdat_ctrl.sv @@
// Sequencer state machine of the step detector.
`default_nettype none

module sdat_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  sdat_pkg::sts_t    sts_i,
  output sdat_pkg::cmd_t    cmd_o
);

  sdat_pkg::state_e state_q, state_d;
  logic [sdat_pkg::CntW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdat_pkg::StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      sdat_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          state_d      = sts_i.item_skip ? sdat_pkg::StEmit : sdat_pkg::StSquare;
        end
      end
      sdat_pkg::StSquare: begin
        cmd_o.sq_step = 1'b1;
        cmd_o.sq_sel  = sdat_pkg::axis_e'(cnt_q[1:0]);
        if (cnt_q == sdat_pkg::CntW'(sdat_pkg::SqSteps - 1)) begin
          cnt_d   = '0;
          state_d = sdat_pkg::StRoot;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      sdat_pkg::StRoot: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == sdat_pkg::CntW'(sdat_pkg::RootSteps - 1)) begin
          cnt_d   = '0;
          state_d = sdat_pkg::StDivMul;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      sdat_pkg::StDivMul: begin
        cmd_o.div_mul = 1'b1;
        state_d       = sdat_pkg::StDivProd;
      end
      sdat_pkg::StDivProd: begin
        cmd_o.div_prod = 1'b1;
        state_d        = sdat_pkg::StDivFix;
      end
      sdat_pkg::StDivFix: begin
        cmd_o.div_fix = 1'b1;
        state_d       = sdat_pkg::StWindow;
      end
      sdat_pkg::StWindow: begin
        cmd_o.win_upd = 1'b1;
        state_d       = sdat_pkg::StDetect;
      end
      sdat_pkg::StDetect: begin
        cmd_o.detect = 1'b1;
        state_d      = sdat_pkg::StEmit;
      end
      sdat_pkg::StEmit: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = sdat_pkg::StIdle;
        end
      end
      default: state_d = sdat_pkg::StIdle;
    endcase
  end

  assign out_valid_d = cmd_o.emit | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=>
      (state_q == sdat_pkg::StSquare || state_q == sdat_pkg::StEmit))
    else $error("accepted transaction did not start work");

  a_emit_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("emitted result not presented");

  a_square_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdat_pkg::StSquare && cnt_q == sdat_pkg::CntW'(sdat_pkg::SqSteps - 1))
      |=> state_q == sdat_pkg::StRoot)
    else $error("square phase length wrong");

  a_root_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdat_pkg::StRoot && cnt_q == sdat_pkg::CntW'(sdat_pkg::RootSteps - 1))
      |=> state_q == sdat_pkg::StDivMul)
    else $error("root phase length wrong");

endmodule

`default_nettype wire

@@ rtl/core/sdat_dp.sv @@
// Datapath: squares, integer root, low-pass, window tracking and step decision.
`default_nettype none

module sdat_dp #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  sdat_pkg::in_item_t in_data_i,
  input  sdat_pkg::cfg_t     cfg_i,
  input  sdat_pkg::cmd_t     cmd_i,
  output sdat_pkg::sts_t     sts_o,
  output sdat_pkg::out_item_t out_data_o
);

  localparam int unsigned LW    = sdat_pkg::LevelW;
  localparam int unsigned MagW  = 16 + FRAC_BITS;
  localparam int unsigned VW    = ((MagW > LW + 4) ? MagW : LW + 4) + 1;
  localparam int unsigned PW    = VW + 32;
  localparam int unsigned QW    = PW - sdat_pkg::DivShift;
  localparam int unsigned BandW = 16 + FRAC_BITS;
  localparam int unsigned CmpW  = ((BandW > LW) ? BandW : LW) + 1;
  localparam logic [LW-1:0] ThrReset =
    sdat_pkg::sat_level(32'(sdat_pkg::InitThrReset) << FRAC_BITS);

  // algorithm state
  logic signed [15:0] good_x_q, good_y_q, good_z_q;
  logic [LW-1:0] smooth_q, smooth_d;
  logic [LW-1:0] max_q, min_q, thr_q;
  logic [5:0]    wcount_q;
  logic          high_q;
  logic [31:0]   last_q, steps_q;

  // working registers
  logic [31:0]   time_q, n_q, root_q, bit_q;
  logic [VW-1:0] v_q;
  logic [PW-1:0] prod_q;
  logic          taken_q;
  sdat_pkg::out_item_t out_q;

  assign sts_o.item_skip = ~in_data_i.imu_ready;

  // square and accumulate
  logic signed [15:0] sq_in;
  logic signed [31:0] sq_prod;
  always_comb begin
    case (cmd_i.sq_sel)
      sdat_pkg::AxisX: sq_in = good_x_q;
      sdat_pkg::AxisY: sq_in = good_y_q;
      sdat_pkg::AxisZ: sq_in = good_z_q;
      default:         sq_in = '0;
    endcase
  end
  assign sq_prod = sq_in * sq_in;

  // one root digit
  logic [32:0] trial;
  logic        trial_fits;
  assign trial      = {1'b0, root_q} + {1'b0, bit_q};
  assign trial_fits = {1'b0, n_q} >= trial;

  // low-pass numerator and reciprocal product
  logic [VW-1:0] mag_ext, s_ext, v_now;
  logic [PW-1:0] prod_now;
  assign mag_ext  = VW'(root_q[15:0]) << FRAC_BITS;
  assign s_ext    = VW'(smooth_q);
  assign v_now    = mag_ext + (s_ext << 3) + s_ext;
  assign prod_now = PW'(v_q) * PW'(sdat_pkg::DivRecip);

  // quotient correction and saturation
  logic [QW-1:0] q_est, q_fix;
  logic [VW-1:0] rem;
  always_comb begin
    q_est = prod_q[PW-1:sdat_pkg::DivShift];
    rem   = v_q - (VW'(q_est) << 3) - (VW'(q_est) << 1);
    q_fix = (rem >= VW'(sdat_pkg::DivConst)) ? q_est + 1'b1 : q_est;
    smooth_d = (q_fix > QW'(sdat_pkg::LevelMax)) ? sdat_pkg::LevelMax : q_fix[LW-1:0];
  end

  // window tracking
  logic [LW-1:0] max_n, min_n;
  logic [5:0]    wcount_n;
  logic          win_done;
  logic [LW:0]   mid_sum;
  assign max_n    = (smooth_q > max_q) ? smooth_q : max_q;
  assign min_n    = (smooth_q < min_q) ? smooth_q : min_q;
  assign wcount_n = wcount_q + 6'd1;
  assign win_done = (wcount_n >= cfg_i.window_samples) || (wcount_n == 6'd0);
  assign mid_sum  = {1'b0, max_n} + {1'b0, min_n};

  // band compare
  logic [CmpW-1:0] s_c, t_c, b_c;
  logic            above, below, refr_over;
  assign s_c       = CmpW'(smooth_q);
  assign t_c       = CmpW'(thr_q);
  assign b_c       = CmpW'(BandW'(cfg_i.hysteresis_mm) << FRAC_BITS);
  assign above     = s_c > (t_c + b_c);
  assign below     = (s_c + b_c) < t_c;
  assign refr_over = (time_q - last_q) > 32'(cfg_i.refractory_ms);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_x_q <= '0;
      good_y_q <= '0;
      good_z_q <= sdat_pkg::GoodZReset;
      smooth_q <= '0;
      max_q    <= '0;
      min_q    <= sdat_pkg::LevelMax;
      wcount_q <= '0;
      thr_q    <= ThrReset;
      high_q   <= 1'b0;
      last_q   <= '0;
      steps_q  <= '0;
    end else begin
      if (cmd_i.accept && in_data_i.imu_ready && in_data_i.read_ok) begin
        good_x_q <= in_data_i.accel_x;
        good_y_q <= in_data_i.accel_y;
        good_z_q <= in_data_i.accel_z;
      end
      if (cmd_i.div_fix) begin
        smooth_q <= smooth_d;
      end
      if (cfg_i.thr_load) begin
        thr_q <= sdat_pkg::sat_level(32'(cfg_i.initial_threshold_mm) << FRAC_BITS);
      end else if (cmd_i.win_upd && win_done) begin
        thr_q <= mid_sum[LW:1];
      end
      if (cmd_i.win_upd) begin
        if (win_done) begin
          max_q    <= smooth_q;
          min_q    <= smooth_q;
          wcount_q <= '0;
        end else begin
          max_q    <= max_n;
          min_q    <= min_n;
          wcount_q <= wcount_n;
        end
      end
      if (cmd_i.detect) begin
        if (above) begin
          if (!high_q && refr_over) begin
            steps_q <= steps_q + 32'd1;
            last_q  <= time_q;
          end
          high_q <= 1'b1;
        end else if (below) begin
          high_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      time_q  <= in_data_i.time_ms;
      taken_q <= 1'b0;
      n_q     <= '0;
      root_q  <= '0;
      bit_q   <= sdat_pkg::RootBitInit;
    end
    if (cmd_i.sq_step) begin
      n_q <= n_q + 32'(unsigned'(sq_prod));
    end
    if (cmd_i.root_step) begin
      if (trial_fits) begin
        n_q    <= n_q - trial[31:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.div_mul) begin
      v_q <= v_now;
    end
    // reciprocal product is taken from the numerator registered in the step before
    if (cmd_i.div_prod) begin
      prod_q <= prod_now;
    end
    if (cmd_i.detect && above && !high_q && refr_over) begin
      taken_q <= 1'b1;
    end
    if (cmd_i.emit) begin
      out_q.step_total      <= steps_q;
      out_q.step_taken      <= taken_q;
      out_q.filtered_level  <= smooth_q;
      out_q.threshold_level <= thr_q;
      out_q.armed_high      <= high_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire
